[src/rpaf_pkg.sv]
// Shared types, constants and codes for the radio packet accept filter.
package rpaf_pkg;

   localparam int MAX_PACKET = 64;
   localparam logic [7:0] MAX_LEN = 8'(MAX_PACKET);

   localparam logic [7:0] MAGIC_0     = 8'h47;
   localparam logic [7:0] MAGIC_1     = 8'h4F;
   localparam logic [7:0] VER_LOW     = 8'h31;
   localparam logic [7:0] VER_HIGH    = 8'h35;
   localparam logic [7:0] SUM_BACK    = 8'd6;
   localparam logic [7:0] KEY_POS     = 8'd15;
   localparam logic [3:0] KEY_LOW     = 4'd3;
   localparam logic [3:0] KEY_HIGH    = 4'd5;
   localparam logic [7:0] MIN_LEN     = 8'd8;
   localparam logic [7:0] MIN_LEN_KEY = 8'd16;
   localparam logic [7:0] POS_MAX     = 8'd255;
   localparam logic [7:0] POS_MAGIC_0 = 8'd0;
   localparam logic [7:0] POS_MAGIC_1 = 8'd1;
   localparam logic [7:0] POS_VERSION = 8'd2;

   localparam logic [2:0] FILT_ALL_EVT  = 3'd0;
   localparam logic [2:0] FILT_KEY_EVT  = 3'd1;
   localparam logic [2:0] FILT_PASS_ALL = 3'd4;

   localparam logic OP_BYTE  = 1'b0;
   localparam logic OP_RADIO = 1'b1;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_MAGIC   = 3'd1;
   localparam logic [2:0] ST_VERSION = 3'd2;
   localparam logic [2:0] ST_SUM     = 3'd3;
   localparam logic [2:0] ST_KEY     = 3'd4;
   localparam logic [2:0] ST_SHORT   = 3'd5;
   localparam logic [2:0] ST_RADIO   = 3'd6;

   typedef struct packed {
      logic       op;
      logic [7:0] data_byte;
      logic [7:0] pkt_len;
      logic       last;
   } item_type;

   typedef struct packed {
      logic        accepted;
      logic [2:0]  status;
      logic [31:0] packets_received;
      logic [7:0]  radio_errors;
   } result_type;

   typedef struct packed {
      logic fire;       // request leaves the input register this cycle
      logic has_result; // request produces a result
   } track_ctl_type;

endpackage

[src/rpaf_track.sv]
// Per-packet check state, counters and the accept decision.
module rpaf_track (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [2:0]               filter_mode,
   input  logic                     fire,
   input  rpaf_pkg::item_type       item,
   output rpaf_pkg::track_ctl_type  ctl,
   output rpaf_pkg::result_type     result
);

   logic [7:0]  byte_position_ff, byte_position_in;
   logic [15:0] running_sum_ff, running_sum_in;
   logic        magic_good_ff, magic_good_in;
   logic        version_good_ff, version_good_in;
   logic [3:0]  key_nibble_ff, key_nibble_in;
   logic [15:0] expected_sum_ff, expected_sum_in;
   logic [31:0] packet_count_ff, packet_count_in;
   logic [7:0]  error_count_ff, error_count_in;

   logic [7:0]  len_c;
   logic [7:0]  sum_at;
   logic [7:0]  min_len;
   logic [7:0]  pos_n;
   logic        in_range;
   logic [15:0] sum_n;
   logic [15:0] exp_n;
   logic        magic_n;
   logic        version_n;
   logic [3:0]  key_n;
   logic        clear_pkt;

   always_comb begin
      len_c    = (item.pkt_len > rpaf_pkg::MAX_LEN) ? rpaf_pkg::MAX_LEN : item.pkt_len;
      sum_at   = len_c - rpaf_pkg::SUM_BACK;
      in_range = byte_position_ff < len_c;
      pos_n    = (byte_position_ff == rpaf_pkg::POS_MAX) ? rpaf_pkg::POS_MAX
                                                         : byte_position_ff + 8'd1;
      min_len  = (filter_mode == rpaf_pkg::FILT_KEY_EVT) ? rpaf_pkg::MIN_LEN_KEY
                                                         : rpaf_pkg::MIN_LEN;

      magic_n   = magic_good_ff;
      version_n = version_good_ff;
      key_n     = key_nibble_ff;
      sum_n     = running_sum_ff;
      exp_n     = expected_sum_ff;
      if (in_range) begin
         if (byte_position_ff == rpaf_pkg::POS_MAGIC_0 && item.data_byte != rpaf_pkg::MAGIC_0)
            magic_n = 1'b0;
         if (byte_position_ff == rpaf_pkg::POS_MAGIC_1 && item.data_byte != rpaf_pkg::MAGIC_1)
            magic_n = 1'b0;
         if (byte_position_ff == rpaf_pkg::POS_VERSION)
            version_n = item.data_byte >= rpaf_pkg::VER_LOW &&
                        item.data_byte <= rpaf_pkg::VER_HIGH;
         if (byte_position_ff == rpaf_pkg::KEY_POS)
            key_n = item.data_byte[3:0];
         // checksum word sits big-endian six bytes from the end
         if (len_c >= rpaf_pkg::SUM_BACK) begin
            if (byte_position_ff < sum_at)
               sum_n = running_sum_ff + {8'd0, item.data_byte};
            else if (byte_position_ff == sum_at)
               exp_n = {item.data_byte, expected_sum_ff[7:0]};
            else if (byte_position_ff == sum_at + 8'd1)
               exp_n = {expected_sum_ff[15:8], item.data_byte};
         end
      end

      byte_position_in = pos_n;
      running_sum_in   = sum_n;
      magic_good_in    = magic_n;
      version_good_in  = version_n;
      key_nibble_in    = key_n;
      expected_sum_in  = exp_n;
      packet_count_in  = packet_count_ff;
      error_count_in   = error_count_ff;
      clear_pkt        = 1'b0;

      result.accepted = 1'b0;
      result.status   = rpaf_pkg::ST_OK;

      if (item.op == rpaf_pkg::OP_RADIO) begin
         error_count_in = error_count_ff + 8'd1;
         clear_pkt      = 1'b1;
         result.status  = rpaf_pkg::ST_RADIO;
      end else if (item.last) begin
         packet_count_in = packet_count_ff + 32'd1;
         clear_pkt       = 1'b1;
         if (filter_mode == rpaf_pkg::FILT_PASS_ALL) begin
            result.accepted = 1'b1;
         end else if (len_c < min_len || pos_n < len_c) begin
            result.status = rpaf_pkg::ST_SHORT;
         end else if (!magic_n) begin
            result.status = rpaf_pkg::ST_MAGIC;
         end else if (!version_n) begin
            result.status = rpaf_pkg::ST_VERSION;
         end else if (sum_n != exp_n) begin
            result.status = rpaf_pkg::ST_SUM;
         end else if (filter_mode == rpaf_pkg::FILT_KEY_EVT &&
                      (key_n < rpaf_pkg::KEY_LOW || key_n > rpaf_pkg::KEY_HIGH)) begin
            result.status = rpaf_pkg::ST_KEY;
         end else begin
            result.accepted = 1'b1;
         end
      end

      if (clear_pkt) begin
         byte_position_in = 8'd0;
         running_sum_in   = 16'd0;
         magic_good_in    = 1'b1;
         version_good_in  = 1'b0;
         key_nibble_in    = 4'd0;
         expected_sum_in  = 16'd0;
      end

      result.packets_received = packet_count_in;
      result.radio_errors     = error_count_in;
      ctl.fire       = fire;
      ctl.has_result = item.op == rpaf_pkg::OP_RADIO || item.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_position_ff <= 8'd0;
         running_sum_ff   <= 16'd0;
         magic_good_ff    <= 1'b1;
         version_good_ff  <= 1'b0;
         key_nibble_ff    <= 4'd0;
         expected_sum_ff  <= 16'd0;
         packet_count_ff  <= 32'd0;
         error_count_ff   <= 8'd0;
      end else if (fire) begin
         byte_position_ff <= byte_position_in;
         running_sum_ff   <= running_sum_in;
         magic_good_ff    <= magic_good_in;
         version_good_ff  <= version_good_in;
         key_nibble_ff    <= key_nibble_in;
         expected_sum_ff  <= expected_sum_in;
         packet_count_ff  <= packet_count_in;
         error_count_ff   <= error_count_in;
      end
   end

endmodule

[src/radio_packet_accept_filter_unit.sv]
// Top level of the radio packet accept filter: input register, result register, handshakes.
//
//  channel | direction | handshake         | payload
//  req     | in        | req_valid/stall   | op, data_byte, pkt_len, last
//  rsp     | out       | rsp_valid/stall   | accepted, status, packets_received, radio_errors
//  csr     | in        | csr_valid/ready   | filter_mode
//
// One request per cycle while req_stall is low; a result passes the input and result registers.
// The per-packet state loop closes through the logic between the input and result registers.
// Reset clears the packet state, both counters and sets filter_mode to key mode.
// req_stall rises only when a request that yields a result meets a full, stalled
// result register.
module radio_packet_accept_filter_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [7:0]  req_data_byte,
   input  logic [7:0]  req_pkt_len,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_accepted,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_packets_received,
   output logic [7:0]  rsp_radio_errors,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_filter_mode
);

   logic                    in_valid_ff, in_valid_in;
   rpaf_pkg::item_type      in_item_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   rpaf_pkg::result_type    rsp_ff;
   logic [2:0]              filter_mode_ff;
   logic                    blocked;
   logic                    fire;
   rpaf_pkg::track_ctl_type ctl;
   rpaf_pkg::result_type    result;

   rpaf_track u_track (
      .clock       (clock),
      .reset       (reset),
      .filter_mode (filter_mode_ff),
      .fire        (fire),
      .item        (in_item_ff),
      .ctl         (ctl),
      .result      (result)
   );

   always_comb begin
      blocked      = in_valid_ff && ctl.has_result && rsp_valid_ff && rsp_stall;
      fire         = in_valid_ff && !blocked;
      req_stall    = blocked;
      in_valid_in  = blocked ? in_valid_ff : req_valid;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (ctl.fire && ctl.has_result)
         rsp_valid_in = 1'b1;
   end

   assign csr_ready            = 1'b1;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_accepted         = rsp_ff.accepted;
   assign rsp_status           = rsp_ff.status;
   assign rsp_packets_received = rsp_ff.packets_received;
   assign rsp_radio_errors     = rsp_ff.radio_errors;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         filter_mode_ff <= rpaf_pkg::FILT_KEY_EVT;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready)
            filter_mode_ff <= csr_filter_mode;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_item_ff.op        <= req_op;
         in_item_ff.data_byte <= req_data_byte;
         in_item_ff.pkt_len   <= req_pkt_len;
         in_item_ff.last      <= req_last;
      end
      if (ctl.fire && ctl.has_result)
         rsp_ff <= result;
   end

`ifndef SYNTHESIS
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without a stalled result");

   a_accept_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_accepted) |-> (rsp_status == rpaf_pkg::ST_OK))
      else $error("accepted packet with non-ok status");

   a_radio_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_status == rpaf_pkg::ST_RADIO) |-> !rsp_accepted)
      else $error("radio error reported as accepted");

   a_reset_empty: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> (!rsp_valid && !req_stall))
      else $error("pipeline not empty after reset");
`endif

endmodule

[tb/sv/tb_radio_packet_accept_filter_unit.sv]
// Self-checking testbench for the radio packet accept filter: byte streams checked against a predictor.
module tb_radio_packet_accept_filter_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import rpaf_pkg::*;

   localparam logic [2:0] FILT_CLASS_B   = 3'd2;
   localparam logic [2:0] FILT_CLASS_C   = 3'd3;
   localparam logic [2:0] MODE_SPARE_LO  = 3'd5;
   localparam logic [2:0] MODE_SPARE_MID = 3'd6;
   localparam logic [2:0] MODE_SPARE_HI  = 3'd7;

   localparam int IDLE_LIMIT   = 1000;
   localparam int HOLD_CYCLES  = 80;
   localparam int PHASE_ITEMS  = 25;
   localparam int TAIL_ITEMS   = 40;
   localparam int DRAIN_CYCLES = 4;

   typedef enum int {FLAW_NONE, FLAW_MAGIC, FLAW_VERSION, FLAW_SUM, FLAW_KEY, FLAW_NOISE} flaw_e;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_op = OP_BYTE;
   logic [7:0]  req_data_byte = '0;
   logic [7:0]  req_pkt_len = '0;
   logic        req_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_accepted;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_packets_received;
   logic [7:0]  rsp_radio_errors;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_filter_mode = FILT_KEY_EVT;

   // predictor state, mirrors the block after reset
   logic [2:0]  mode_now   = FILT_KEY_EVT;
   logic [7:0]  pos_count  = '0;
   logic [15:0] sum_acc    = '0;
   logic [15:0] sum_word   = '0;
   logic        magic_ok   = 1'b1;
   logic        version_ok = 1'b0;
   logic [3:0]  key_low    = '0;
   logic [31:0] pkt_total  = '0;
   logic [7:0]  err_total  = '0;

   result_type  expected_verdicts[$];
   logic [7:0]  pkt_bytes[$];

   int mismatches   = 0;
   int items_sent   = 0;
   int quiet_cycles = 0;
   int gap_pct      = 20;
   int stall_pct    = 20;
   bit calm         = 1'b0;
   bit hold_request = 1'b0;

   radio_packet_accept_filter_unit dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_op               (req_op),
      .req_data_byte        (req_data_byte),
      .req_pkt_len          (req_pkt_len),
      .req_last             (req_last),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_accepted         (rsp_accepted),
      .rsp_status           (rsp_status),
      .rsp_packets_received (rsp_packets_received),
      .rsp_radio_errors     (rsp_radio_errors),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_filter_mode      (csr_filter_mode)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void clear_packet();
      pos_count  = '0;
      sum_acc    = '0;
      sum_word   = '0;
      magic_ok   = 1'b1;
      version_ok = 1'b0;
      key_low    = '0;
   endfunction

   function automatic void filter_predict(input item_type it);
      logic [7:0] len;
      logic [7:0] at;
      logic [7:0] min_len;
      result_type v;
      v = '0;
      if (it.op == OP_RADIO) begin
         err_total = err_total + 8'd1;
         clear_packet();
         v.status = ST_RADIO;
         v.packets_received = pkt_total;
         v.radio_errors = err_total;
         expected_verdicts.push_back(v);
         return;
      end
      len = (it.pkt_len > MAX_LEN) ? MAX_LEN : it.pkt_len;
      if (pos_count < len) begin
         if (pos_count == POS_MAGIC_0 && it.data_byte != MAGIC_0) magic_ok = 1'b0;
         if (pos_count == POS_MAGIC_1 && it.data_byte != MAGIC_1) magic_ok = 1'b0;
         if (pos_count == POS_VERSION)
            version_ok = (it.data_byte >= VER_LOW && it.data_byte <= VER_HIGH);
         if (pos_count == KEY_POS) key_low = it.data_byte[3:0];
         if (len >= SUM_BACK) begin
            at = len - SUM_BACK;
            if (pos_count < at) sum_acc = sum_acc + 16'(it.data_byte);
            else if (pos_count == at) sum_word[15:8] = it.data_byte;
            else if (pos_count == at + 8'd1) sum_word[7:0] = it.data_byte;
         end
      end
      if (pos_count != POS_MAX) pos_count = pos_count + 8'd1;
      if (!it.last) return;
      pkt_total = pkt_total + 32'd1;
      min_len = (mode_now == FILT_KEY_EVT) ? MIN_LEN_KEY : MIN_LEN;
      if (mode_now == FILT_PASS_ALL) v.status = ST_OK;
      else if (len < min_len || pos_count < len) v.status = ST_SHORT;
      else if (!magic_ok) v.status = ST_MAGIC;
      else if (!version_ok) v.status = ST_VERSION;
      else if (sum_acc != sum_word) v.status = ST_SUM;
      else if (mode_now == FILT_KEY_EVT && (key_low < KEY_LOW || key_low > KEY_HIGH))
         v.status = ST_KEY;
      else v.status = ST_OK;
      v.accepted = (v.status == ST_OK);
      v.packets_received = pkt_total;
      v.radio_errors = err_total;
      clear_packet();
      expected_verdicts.push_back(v);
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // result checker
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_verdicts.size() == 0) begin
            $display("%0t: unexpected result, expected none actual status %0h accepted %0h",
                     $time, rsp_status, rsp_accepted);
            mismatches++;
         end else begin
            want = expected_verdicts.pop_front();
            check_field("accepted", 32'(want.accepted), 32'(rsp_accepted));
            check_field("status", 32'(want.status), 32'(rsp_status));
            check_field("packets_received", want.packets_received, rsp_packets_received);
            check_field("radio_errors", 32'(want.radio_errors), 32'(rsp_radio_errors));
         end
      end
   end

   // watchdog: counts cycles in which no handshake completes
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
            $display("Verification failed");
            $finish;
         end
      end
   end

   // result side: random stall bursts, plus a long hold-off on demand
   initial begin : rsp_side
      int burst;
      int hold;
      logic stall_next;
      burst = 0;
      hold = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold > 0) begin
            hold--;
            stall_next = 1'b1;
         end else if (burst > 0) begin
            burst--;
            stall_next = 1'b1;
         end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
            burst = $urandom_range(1, 14) - 1;
            stall_next = 1'b1;
         end else begin
            stall_next = 1'b0;
         end
         rsp_stall <= stall_next;
      end
   end

   task automatic send_request(input logic op, input logic [7:0] b, input logic [7:0] len,
                               input logic last);
      item_type it;
      int gap;
      it.op = op;
      it.data_byte = b;
      it.pkt_len = len;
      it.last = last;
      gap = (!calm && $urandom_range(0, 99) < gap_pct) ? $urandom_range(1, 14) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_op        <= op;
      req_data_byte <= b;
      req_pkt_len   <= len;
      req_last      <= last;
      do @(posedge clock); while (req_stall);
      filter_predict(it);
      items_sent++;
   endtask

   task automatic send_radio_error();
      send_request(OP_RADIO, 8'($urandom), 8'($urandom), 1'($urandom));
   endtask

   task automatic release_requests();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic write_mode(input logic [2:0] m);
      release_requests();
      while (expected_verdicts.size() != 0) @(negedge clock);
      // requests without a result may still be in flight
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_valid       <= 1'b1;
      csr_filter_mode <= m;
      do @(posedge clock); while (!csr_ready);
      mode_now = m;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // builds a packet of n bytes in pkt_bytes, well formed apart from the chosen flaw
   function automatic void make_packet(input int n, input flaw_e flaw);
      logic [15:0] s;
      int at;
      int r;
      pkt_bytes.delete();
      for (int i = 0; i < n; i++) pkt_bytes.push_back(8'($urandom));
      if (flaw == FLAW_NOISE) return;
      if (n > 0) pkt_bytes[0] = MAGIC_0;
      if (n > 1) pkt_bytes[1] = MAGIC_1;
      if (n > 2) pkt_bytes[2] = 8'($urandom_range(VER_LOW, VER_HIGH));
      if (n > KEY_POS)
         pkt_bytes[KEY_POS] = {4'($urandom), 4'($urandom_range(KEY_LOW, KEY_HIGH))};
      if (flaw == FLAW_MAGIC && n > 1) begin
         r = $urandom_range(0, 1);
         pkt_bytes[r] = pkt_bytes[r] ^ 8'($urandom_range(1, 255));
      end
      if (flaw == FLAW_VERSION && n > 2)
         pkt_bytes[2] = $urandom_range(0, 1) ? 8'($urandom_range(0, VER_LOW - 1))
                                             : 8'($urandom_range(VER_HIGH + 1, 255));
      if (flaw == FLAW_KEY && n > KEY_POS) begin
         r = $urandom_range(0, 12);
         pkt_bytes[KEY_POS][3:0] = 4'((r < KEY_LOW) ? r : r + 3);
      end
      if (n >= SUM_BACK) begin
         at = n - SUM_BACK;
         s = '0;
         for (int i = 0; i < at; i++) s = s + 16'(pkt_bytes[i]);
         if (flaw == FLAW_SUM) s = s ^ (16'd1 << $urandom_range(0, 15));
         pkt_bytes[at] = s[15:8];
         pkt_bytes[at + 1] = s[7:0];
      end
   endfunction

   // wobble gives each byte a length of its own; the last one decides
   task automatic send_packet(input int rep_len, input bit wobble);
      for (int i = 0; i < pkt_bytes.size(); i++)
         send_request(OP_BYTE, pkt_bytes[i], wobble ? 8'($urandom) : 8'(rep_len),
                      i == pkt_bytes.size() - 1);
   endtask

   task automatic random_packet();
      int r;
      int n;
      int rep_len;
      int cut;
      flaw_e flaw;
      r = $urandom_range(0, 19);
      if (r == 0) rep_len = $urandom_range(0, 7);
      else if (r == 1) rep_len = $urandom_range(8, 15);
      else if (r < 17) rep_len = $urandom_range(16, 24);
      else if (r < 19) rep_len = $urandom_range(25, MAX_PACKET);
      else rep_len = $urandom_range(MAX_PACKET + 1, 255);
      n = (rep_len > MAX_PACKET) ? MAX_PACKET : rep_len;
      flaw = ($urandom_range(0, 9) < 6) ? FLAW_NONE : flaw_e'($urandom_range(FLAW_MAGIC, FLAW_NOISE));
      make_packet(n, flaw);
      r = $urandom_range(0, 19);
      if (r == 0 && pkt_bytes.size() > 1) begin
         // fewer bytes arrive than the length claims
         repeat ($urandom_range(1, pkt_bytes.size() - 1)) void'(pkt_bytes.pop_back());
      end else if (r < 3 || rep_len > MAX_PACKET) begin
         repeat ($urandom_range(1, 4)) pkt_bytes.push_back(8'($urandom));
      end
      if (pkt_bytes.size() == 0) pkt_bytes.push_back(8'($urandom));
      if (r == 3) begin
         // radio error part way through: the partial packet is dropped
         cut = $urandom_range(0, pkt_bytes.size() - 1);
         for (int i = 0; i < cut; i++) send_request(OP_BYTE, pkt_bytes[i], 8'(rep_len), 1'b0);
         send_radio_error();
      end else begin
         send_packet(rep_len, r == 4);
      end
   endtask

   task automatic random_action();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) begin
         send_radio_error();
      end else if (r < 12) begin
         repeat ($urandom_range(1, 12))
            send_request(OP_BYTE, 8'($urandom), 8'($urandom), $urandom_range(0, 7) == 0);
      end else begin
         random_packet();
      end
   endtask

   task automatic test_directed();
      // reset leaves the block in key mode
      make_packet(16, FLAW_NONE);
      send_packet(16, 1'b0);
      send_request(OP_RADIO, 8'hFF, 8'hFF, 1'b1);
      pkt_bytes = '{8'h00};
      send_packet(0, 1'b0);
      write_mode(FILT_PASS_ALL);
      pkt_bytes = '{8'hFF};
      send_packet(255, 1'b0);
      write_mode(FILT_ALL_EVT);
      make_packet(8, FLAW_NONE);
      send_packet(8, 1'b0);
   endtask

   task automatic test_backpressure();
      int saved_gap;
      saved_gap = gap_pct;
      gap_pct = 0;
      hold_request = 1'b1;
      repeat (40) send_radio_error();
      gap_pct = saved_gap;
   endtask

   task automatic test_long_packet();
      // position counter must saturate well past the clamped length
      make_packet(MAX_PACKET, FLAW_NONE);
      repeat (260 - MAX_PACKET) pkt_bytes.push_back(8'($urandom));
      send_packet(255, 1'b0);
   endtask

   task automatic test_error_wrap();
      repeat (260) begin
         if ($urandom_range(0, 9) == 0)
            send_request(OP_BYTE, 8'($urandom), 8'($urandom), 1'b0);
         send_radio_error();
      end
   endtask

   task automatic test_random_phases();
      logic [2:0] phase_modes[8];
      int phase_end;
      phase_modes = '{FILT_ALL_EVT, FILT_KEY_EVT, FILT_CLASS_B, FILT_CLASS_C, FILT_PASS_ALL,
                      MODE_SPARE_LO, MODE_SPARE_MID, MODE_SPARE_HI};
      foreach (phase_modes[p]) begin
         write_mode(phase_modes[p]);
         gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
         stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
         phase_end = items_sent + PHASE_ITEMS;
         while (items_sent < phase_end) random_action();
      end
   endtask

   task automatic test_calm_tail();
      int tail_end;
      calm = 1'b1;
      write_mode($urandom_range(0, 1) ? FILT_KEY_EVT : FILT_ALL_EVT);
      tail_end = items_sent + TAIL_ITEMS;
      while (items_sent < tail_end) random_action();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_backpressure();
      test_long_packet();
      test_error_wrap();
      test_random_phases();
      test_calm_tail();
      release_requests();
      while (expected_verdicts.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES * 2) @(posedge clock);
      if (mismatches == 0 && expected_verdicts.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
